// ===== rtl/bfr_pkg.sv =====
package bfr_pkg;

  // Default sizes
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int GLYPH_BYTES_DEF = 4096;
  localparam int MAX_WIDTH_DEF   = 18;

  // Glyph address counter width: holds any base plus a full glyph, and GLYPH_BYTES itself
  localparam int GCNT_W = 17;

  // Display controller command bytes
  localparam logic [7:0] PAGE_CMD    = 8'hB0;
  localparam logic [7:0] COLH_CMD    = 8'h10;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  // Input item kinds
  typedef enum logic [1:0] {
    CMD_LOAD_ENTRY = 2'd0,
    CMD_LOAD_GLYPH = 2'd1,
    CMD_START      = 2'd2,
    CMD_DRAW       = 2'd3
  } cmd_t;

  // One font table entry
  typedef struct packed {
    logic [7:0]  code;
    logic [5:0]  width;
    logic [1:0]  height;
    logic [11:0] base;
  } font_entry_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_ISSUE,
    S_PROBE,
    S_HIT,
    S_PAGE,
    S_COLH,
    S_COLL,
    S_DATA
  } ctrl_state_t;

  // Font table read select
  typedef enum logic [1:0] {
    ENT_RD_NONE,
    ENT_RD_FIRST,
    ENT_RD_LAST,
    ENT_RD_MID
  } ent_rd_t;

  // Output word select
  typedef enum logic [2:0] {
    EM_NONE,
    EM_PAGE,
    EM_COLH,
    EM_COLL,
    EM_DATA
  } emit_t;

  // Controller to datapath
  typedef struct packed {
    logic    accept;
    ent_rd_t ent_rd;
    logic    search_init;
    logic    probe_step;
    logic    hit_latch;
    emit_t   emit;
    logic    row_next;
    logic    advance_col;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic n_zero;
    logic first_gt;
    logic last_lt;
    logic lo_lt_hi;
    logic probe_eq;
    logic height_zero;
    logic width_zero;
    logic row_last;
    logic byte_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/bitmap_font_text_renderer.sv =====
// Bitmap font text renderer. Load font entries (cmd 0) and glyph bytes (cmd 1), set the
// cursor (cmd 2), then send characters (cmd 3); each character found in the table with a
// nonzero height yields a byte stream for a page-addressed display: per glyph page row a
// page command, two column commands and the glyph's column bytes, tlast on the final byte.
// A character is looked up by up to nine binary-search probes, each a registered read of
// the font table plus a compare; bytes leave one a cycle from the output register while
// the sink is ready, with the glyph store read one byte ahead. The font table and glyph
// store are not cleared at reset: only entries that were written may be referenced.
module bitmap_font_text_renderer #(
  parameter int TABLE_DEPTH = bfr_pkg::TABLE_DEPTH_DEF,
  parameter int GLYPH_BYTES = bfr_pkg::GLYPH_BYTES_DEF,
  parameter int MAX_WIDTH   = bfr_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input words
  input  logic        s_tvalid,
  output logic        s_tready,
  // entry_index[7:0], char_code[15:8], glyph_width[21:16], glyph_height[23:22],
  // glyph_address[35:24], glyph_byte[43:36], start_page[47:44], start_column[55:48]
  input  logic [55:0] s_tdata,
  input  logic [1:0]  s_tuser,  // cmd[1:0]
  // Output words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // out_byte[7:0]
  output logic        m_tuser,  // is_data
  output logic        m_tlast,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bfr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_sts_t    sts;
  cmd_t       in_cmd;
  logic [8:0] font_entries;

  assign in_cmd = cmd_t'(s_tuser);

  // Font entry count register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      font_entries <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      font_entries <= pwdata[8:0];
    end
  end
  assign prdata = paddr[2] ? 32'h0 : {23'h0, font_entries};

  bfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_cmd   (in_cmd),
    .sts      (sts),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  bfr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .GLYPH_BYTES (GLYPH_BYTES),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_cmd        (in_cmd),
    .entry_index   (s_tdata[7:0]),
    .char_code     (s_tdata[15:8]),
    .glyph_width   (s_tdata[21:16]),
    .glyph_height  (s_tdata[23:22]),
    .glyph_address (s_tdata[35:24]),
    .glyph_byte    (s_tdata[43:36]),
    .start_page    (s_tdata[47:44]),
    .start_column  (s_tdata[55:48]),
    .font_entries  (font_entries),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast)
  );

endmodule

// ===== rtl/bfr_ram.sv =====
module bfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bfr_ctrl.sv =====
module bfr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  bfr_pkg::cmd_t     in_cmd,
  input  bfr_pkg::dp_sts_t  sts,
  output logic              s_tready,
  output bfr_pkg::ctrl_cmd_t cmd
);
  import bfr_pkg::*;

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid && in_cmd == CMD_DRAW && !sts.n_zero) begin
          state_next = S_FIRST;
        end
      end
      S_FIRST: state_next = sts.first_gt ? S_IDLE : S_LAST;
      S_LAST:  state_next = sts.last_lt ? S_IDLE : S_ISSUE;
      S_ISSUE: state_next = sts.lo_lt_hi ? S_PROBE : S_IDLE;
      S_PROBE: state_next = sts.probe_eq ? S_HIT : S_ISSUE;
      S_HIT:   state_next = sts.height_zero ? S_IDLE : S_PAGE;
      S_PAGE: begin
        if (sts.out_free) state_next = S_COLH;
      end
      S_COLH: begin
        if (sts.out_free) state_next = S_COLL;
      end
      S_COLL: begin
        if (sts.out_free) begin
          if (!sts.width_zero) state_next = S_DATA;
          else if (sts.row_last) state_next = S_IDLE;
          else state_next = S_PAGE;
        end
      end
      S_DATA: begin
        if (sts.out_free && sts.byte_last) begin
          state_next = sts.row_last ? S_IDLE : S_PAGE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready        = 1'b0;
    cmd.accept      = 1'b0;
    cmd.ent_rd      = ENT_RD_NONE;
    cmd.search_init = 1'b0;
    cmd.probe_step  = 1'b0;
    cmd.hit_latch   = 1'b0;
    cmd.emit        = EM_NONE;
    cmd.row_next    = 1'b0;
    cmd.advance_col = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid && in_cmd == CMD_DRAW && !sts.n_zero) cmd.ent_rd = ENT_RD_FIRST;
      end
      S_FIRST: begin
        if (!sts.first_gt) cmd.ent_rd = ENT_RD_LAST;
      end
      S_LAST: begin
        cmd.search_init = !sts.last_lt;
      end
      S_ISSUE: begin
        if (sts.lo_lt_hi) cmd.ent_rd = ENT_RD_MID;
      end
      S_PROBE: begin
        cmd.hit_latch  = sts.probe_eq;
        cmd.probe_step = !sts.probe_eq;
      end
      S_HIT: begin
        cmd.advance_col = sts.height_zero;
      end
      S_PAGE: begin
        if (sts.out_free) cmd.emit = EM_PAGE;
      end
      S_COLH: begin
        if (sts.out_free) cmd.emit = EM_COLH;
      end
      S_COLL: begin
        if (sts.out_free) begin
          cmd.emit = EM_COLL;
          if (sts.width_zero) begin
            cmd.advance_col = sts.row_last;
            cmd.row_next    = !sts.row_last;
          end
        end
      end
      S_DATA: begin
        if (sts.out_free) begin
          cmd.emit = EM_DATA;
          if (sts.byte_last) begin
            cmd.advance_col = sts.row_last;
            cmd.row_next    = !sts.row_last;
          end
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Load a word only into a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit != EM_NONE) |-> sts.out_free)
    else $error("word emitted into a busy output slot");

  // No input taken while a character is in progress
  a_ready_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (cmd.emit == EM_NONE && !cmd.probe_step && !cmd.hit_latch))
    else $error("input ready during character work");

  // Column advance ends the character
  a_adv_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.advance_col |=> (state == S_IDLE))
    else $error("column advanced before character end");

endmodule

// ===== rtl/bfr_dp.sv =====
module bfr_dp #(
  parameter int TABLE_DEPTH = bfr_pkg::TABLE_DEPTH_DEF,
  parameter int GLYPH_BYTES = bfr_pkg::GLYPH_BYTES_DEF,
  parameter int MAX_WIDTH   = bfr_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bfr_pkg::ctrl_cmd_t cmd,
  output bfr_pkg::dp_sts_t   sts,
  input  bfr_pkg::cmd_t      in_cmd,
  input  logic [7:0]         entry_index,
  input  logic [7:0]         char_code,
  input  logic [5:0]         glyph_width,
  input  logic [1:0]         glyph_height,
  input  logic [11:0]        glyph_address,
  input  logic [7:0]         glyph_byte,
  input  logic [3:0]         start_page,
  input  logic [7:0]         start_column,
  input  logic [8:0]         font_entries,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,
  output logic               m_tuser,
  output logic               m_tlast
);
  import bfr_pkg::*;

  localparam int TE_AW = $clog2(TABLE_DEPTH);
  localparam int GA_AW = $clog2(GLYPH_BYTES);

  font_entry_t ent_wdata, ent_rdata;
  logic [TE_AW-1:0] ent_raddr;
  logic        ent_we;
  logic [8:0]  n_eff, n_m1, mid_calc;
  logic [9:0]  mid_sum;
  logic [8:0]  lo, hi, mid;
  logic [7:0]  code_q;
  logic [5:0]  hit_width, width_clamp, k;
  logic [1:0]  hit_height, row;
  logic [GCNT_W-1:0] gaddr, g_raddr_full, g_waddr_full;
  logic        g_we, g_re, g_oob;
  logic [7:0]  g_rdata, glyph_now;
  logic [3:0]  cursor_page, page_sum;
  logic [7:0]  cursor_column;

  // Effective entry count and search midpoint
  assign n_eff    = (font_entries > 9'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH) : font_entries;
  assign n_m1     = n_eff - 9'd1;
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_calc = mid_sum[9:1];

  // Font table
  assign width_clamp = (glyph_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : glyph_width;
  assign ent_wdata   = '{code: char_code, width: width_clamp, height: glyph_height,
                         base: glyph_address};
  assign ent_we      = cmd.accept && in_cmd == CMD_LOAD_ENTRY &&
                       ({1'b0, entry_index} < 9'(TABLE_DEPTH));

  always_comb begin
    case (cmd.ent_rd)
      ENT_RD_LAST: ent_raddr = n_m1[TE_AW-1:0];
      ENT_RD_MID:  ent_raddr = mid_calc[TE_AW-1:0];
      default:     ent_raddr = '0;
    endcase
  end

  bfr_ram #(
    .WIDTH ($bits(font_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (entry_index[TE_AW-1:0]),
    .wdata (ent_wdata),
    .re    (cmd.ent_rd != ENT_RD_NONE),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // Glyph store; prefetch on the page command and on each data word
  assign g_waddr_full = GCNT_W'(glyph_address);
  assign g_we         = cmd.accept && in_cmd == CMD_LOAD_GLYPH &&
                        (g_waddr_full < GCNT_W'(GLYPH_BYTES));
  assign g_re         = (cmd.emit == EM_PAGE) || (cmd.emit == EM_DATA);
  assign g_raddr_full = (cmd.emit == EM_DATA) ? gaddr + GCNT_W'(1) : gaddr;

  bfr_ram #(
    .WIDTH (8),
    .DEPTH (GLYPH_BYTES)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr_full[GA_AW-1:0]),
    .wdata (glyph_byte),
    .re    (g_re),
    .raddr (g_raddr_full[GA_AW-1:0]),
    .rdata (g_rdata)
  );

  // Track reads past the end of the store; they read as zero
  always_ff @(posedge clk) begin
    if (g_re) begin
      g_oob <= !(g_raddr_full < GCNT_W'(GLYPH_BYTES));
    end
  end
  assign glyph_now = g_oob ? 8'h00 : g_rdata;

  // Search and glyph walk registers
  always_ff @(posedge clk) begin
    if (cmd.accept && in_cmd == CMD_DRAW) code_q <= char_code;
    if (cmd.search_init) begin
      lo <= '0;
      hi <= n_eff;
    end
    if (cmd.ent_rd == ENT_RD_MID) mid <= mid_calc;
    if (cmd.probe_step) begin
      if (ent_rdata.code > code_q) hi <= mid;
      else lo <= mid + 9'd1;
    end
    if (cmd.hit_latch) begin
      hit_width  <= ent_rdata.width;
      hit_height <= ent_rdata.height;
      gaddr      <= GCNT_W'(ent_rdata.base);
      row        <= '0;
    end
    if (cmd.emit == EM_DATA) begin
      gaddr <= gaddr + GCNT_W'(1);
    end
    // Restart the byte count per row, else count data words
    if (cmd.hit_latch || cmd.row_next) begin
      k <= '0;
    end else if (cmd.emit == EM_DATA) begin
      k <= k + 6'd1;
    end
    if (cmd.row_next) begin
      row <= row + 2'd1;
    end
  end

  // Cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_page   <= '0;
      cursor_column <= '0;
    end else begin
      if (cmd.accept && in_cmd == CMD_START) begin
        cursor_page   <= start_page;
        cursor_column <= start_column;
      end else if (cmd.accept && in_cmd == CMD_DRAW) begin
        cursor_column <= cursor_column + 8'd1;
      end else if (cmd.advance_col) begin
        cursor_column <= cursor_column + {2'b00, hit_width};
      end
    end
  end

  assign page_sum = cursor_page + {2'b00, row};

  // Status
  assign sts.n_zero      = (n_eff == 9'd0);
  assign sts.first_gt    = (ent_rdata.code > code_q);
  assign sts.last_lt     = (ent_rdata.code < code_q);
  assign sts.lo_lt_hi    = (lo < hi);
  assign sts.probe_eq    = (ent_rdata.code == code_q);
  assign sts.height_zero = (hit_height == 2'd0);
  assign sts.width_zero  = (hit_width == 6'd0);
  assign sts.row_last    = (row == hit_height - 2'd1);
  assign sts.byte_last   = (k == hit_width - 6'd1);
  assign sts.out_free    = !m_tvalid || m_tready;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit != EM_NONE) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EM_PAGE: begin
        m_tuser <= 1'b0;
        m_tdata <= PAGE_CMD | {4'h0, page_sum};
        m_tlast <= 1'b0;
      end
      EM_COLH: begin
        m_tuser <= 1'b0;
        m_tdata <= COLH_CMD | {4'h0, cursor_column[7:4]};
        m_tlast <= 1'b0;
      end
      EM_COLL: begin
        m_tuser <= 1'b0;
        m_tdata <= cursor_column & NIBBLE_MASK;
        m_tlast <= sts.width_zero && sts.row_last;
      end
      EM_DATA: begin
        m_tuser <= 1'b1;
        m_tdata <= glyph_now;
        m_tlast <= sts.byte_last && sts.row_last;
      end
      default: begin
        m_tuser <= m_tuser;
      end
    endcase
  end

  // Rows stay within the glyph height
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit != EM_NONE) |-> (row < hit_height))
    else $error("page row beyond glyph height");

  // Data words stay within the glyph width
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit == EM_DATA) |-> (k < hit_width))
    else $error("data word beyond glyph width");

endmodule

// ===== bench/render_check.sv =====
module render_check #(
  parameter logic [2:0] ENTRIES_ADDR = '0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors,
  output int          outstanding
);
  import bfr_pkg::*;

  localparam int REPORT_CAP = 40;

  // Input word fields, last field in the top bits
  typedef struct packed {
    logic [7:0]  start_column;
    logic [3:0]  start_page;
    logic [7:0]  glyph_byte;
    logic [11:0] glyph_address;
    logic [1:0]  glyph_height;
    logic [5:0]  glyph_width;
    logic [7:0]  char_code;
    logic [7:0]  entry_index;
  } text_word_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] value;
    logic       last;
  } disp_word_t;

  font_entry_t font_tab [TABLE_DEPTH_DEF];
  logic [7:0]  glyph_mem [GLYPH_BYTES_DEF];
  logic [3:0]  cur_page;
  logic [7:0]  cur_col;
  logic [8:0]  entry_count;
  disp_word_t  expected_bytes [$];

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (errors < REPORT_CAP)
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Probe first entry, last entry, then bisect; the outcome stands even if unsorted
  function automatic logic find_glyph(input logic [7:0] code, output font_entry_t hit);
    int n;
    int lo;
    int hi;
    int mid;
    n = (entry_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(entry_count);
    hit = '0;
    if (n == 0 || font_tab[0].code > code || font_tab[n-1].code < code)
      return 1'b0;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (font_tab[mid].code == code) begin
        hit = font_tab[mid];
        return 1'b1;
      end
      if (font_tab[mid].code > code)
        hi = mid;
      else
        lo = mid + 1;
    end
    return 1'b0;
  endfunction

  function automatic void queue_byte(input logic is_data, input logic [7:0] value,
                                     inout int seen, input int total);
    seen++;
    expected_bytes.push_back('{is_data: is_data, value: value, last: seen == total});
  endfunction

  // Expected display words for one character, cursor updated as the block does
  function automatic void render_char(input logic [7:0] code);
    font_entry_t ent;
    int          addr;
    int          total;
    int          seen;
    logic [3:0]  pg;
    logic [7:0]  gbyte;
    cur_col = cur_col + 8'd1;
    if (!find_glyph(code, ent))
      return;
    total = int'(ent.height) * (3 + int'(ent.width));
    seen = 0;
    addr = int'(ent.base);
    for (int r = 0; r < int'(ent.height); r++) begin
      pg = cur_page + r[3:0];
      queue_byte(1'b0, PAGE_CMD | {4'h0, pg}, seen, total);
      queue_byte(1'b0, COLH_CMD | {4'h0, cur_col[7:4]}, seen, total);
      queue_byte(1'b0, cur_col & NIBBLE_MASK, seen, total);
      for (int k = 0; k < int'(ent.width); k++) begin
        gbyte = (addr < GLYPH_BYTES_DEF) ? glyph_mem[addr] : 8'h00;
        queue_byte(1'b1, gbyte, seen, total);
        addr++;
      end
    end
    cur_col = cur_col + {2'b00, ent.width};
  endfunction

  always @(posedge clk) begin
    text_word_t tw;
    disp_word_t want;
    if (rst) begin
      cur_page = '0;
      cur_col = '0;
      entry_count = '0;
      expected_bytes.delete();
    end else begin
      // Track register writes, verify read-back
      if (psel && penable && pready && paddr == ENTRIES_ADDR) begin
        if (pwrite)
          entry_count = pwdata[8:0];
        else
          check_field("prdata", {23'd0, entry_count}, prdata);
      end
      // Compare each output word with the oldest expectation
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          if (errors < REPORT_CAP)
            $error("unexpected display word: is_data %0d out_byte 0x%0h last %0d",
                   m_tuser, m_tdata, m_tlast);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("is_data", 32'(want.is_data), 32'(m_tuser));
          check_field("out_byte", 32'(want.value), 32'(m_tdata));
          check_field("last", 32'(want.last), 32'(m_tlast));
        end
      end
      // Apply each accepted input word to the shadow state
      if (s_tvalid && s_tready) begin
        tw = text_word_t'(s_tdata);
        case (cmd_t'(s_tuser))
          CMD_LOAD_ENTRY: begin
            font_tab[tw.entry_index] = '{
              code:   tw.char_code,
              width:  (tw.glyph_width > MAX_WIDTH_DEF) ? 6'(MAX_WIDTH_DEF) : tw.glyph_width,
              height: tw.glyph_height,
              base:   tw.glyph_address
            };
          end
          CMD_LOAD_GLYPH: begin
            glyph_mem[tw.glyph_address] = tw.glyph_byte;
          end
          CMD_START: begin
            cur_page = tw.start_page;
            cur_col = tw.start_column;
          end
          default: begin
            render_char(tw.char_code);
          end
        endcase
      end
    end
    outstanding <= expected_bytes.size();
  end

endmodule

// ===== bench/bitmap_font_text_renderer_test.sv =====
module bitmap_font_text_renderer_test;
  import bfr_pkg::*;

  localparam logic [2:0] ENTRIES_ADDR = 3'd0;
  localparam int GLYPH_POOL  = 64;
  localparam int TAIL_BASE   = GLYPH_BYTES_DEF - 6;
  localparam int SETTLE      = 60;
  localparam int HOLD_LEN    = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 25;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = CMD_LOAD_ENTRY;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = ENTRIES_ADDR;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        hold_go = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          errors;
  int          outstanding;

  always #1 clk = ~clk;

  bitmap_font_text_renderer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  render_check #(.ENTRIES_ADDR(ENTRIES_ADDR)) render_watch (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .errors(errors), .outstanding(outstanding)
  );

  // Sink: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_LEN;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offer one word, with random idle cycles ahead of it
  task automatic send_word(input cmd_t kind, input logic [55:0] payload);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= payload;
    do @(posedge clk); while (!s_tready);
  endtask

  // Random filler in the fields a command does not use
  function automatic logic [55:0] noise_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[55:0];
  endfunction

  task automatic load_entry(input logic [7:0] slot, input logic [7:0] code,
                            input logic [5:0] wid, input logic [1:0] ht,
                            input logic [11:0] base);
    logic [55:0] w;
    w = noise_word();
    w[7:0] = slot;
    w[15:8] = code;
    w[21:16] = wid;
    w[23:22] = ht;
    w[35:24] = base;
    send_word(CMD_LOAD_ENTRY, w);
  endtask

  // Pick a glyph whose bytes lie in written memory or past the end of the store
  task automatic load_random_entry(input logic [7:0] slot, input logic [7:0] code);
    logic [5:0]  wid;
    logic [1:0]  ht;
    logic [11:0] base;
    int          span;
    wid = 6'($urandom_range(0, 63));
    ht = 2'($urandom_range(0, 3));
    span = int'(ht) * ((wid > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(wid));
    if ($urandom_range(0, 7) == 0)
      base = 12'(TAIL_BASE + $urandom_range(0, 5));
    else
      base = 12'($urandom_range(0, GLYPH_POOL - span));
    load_entry(slot, code, wid, ht, base);
  endtask

  task automatic load_glyph(input logic [11:0] addr, input logic [7:0] value);
    logic [55:0] w;
    w = noise_word();
    w[35:24] = addr;
    w[43:36] = value;
    send_word(CMD_LOAD_GLYPH, w);
  endtask

  task automatic start_text(input logic [3:0] page, input logic [7:0] col);
    logic [55:0] w;
    w = noise_word();
    w[47:44] = page;
    w[55:48] = col;
    send_word(CMD_START, w);
  endtask

  task automatic draw(input logic [7:0] code);
    logic [55:0] w;
    w = noise_word();
    w[15:8] = code;
    send_word(CMD_DRAW, w);
  endtask

  // Ascending table: odd codes, then the top code repeated
  function automatic logic [7:0] sorted_code(input int slot);
    return (slot < 128) ? 8'(2 * slot + 1) : 8'hFF;
  endfunction

  // Hold the input until every expected word has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write the entry count while idle, then read it back
  task automatic set_entries(input logic [8:0] count);
    logic [31:0] v;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    v = $urandom;
    v[8:0] = count;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ENTRIES_ADDR;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly characters, mixed with cursor moves and font updates
  task automatic random_item();
    int          pick;
    int          slot;
    logic [7:0]  code;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 9) < 7)
        code = 8'(2 * $urandom_range(0, 127) + 1);
      else
        code = 8'($urandom_range(0, 255));
      draw(code);
    end else if (pick < 70) begin
      start_text(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      load_glyph(12'($urandom_range(0, GLYPH_BYTES_DEF - 1)), 8'($urandom_range(0, 255)));
    end else begin
      slot = $urandom_range(0, TABLE_DEPTH_DEF - 1);
      if ($urandom_range(0, 3) == 0)
        code = 8'($urandom_range(0, 255));
      else
        code = sorted_code(slot);
      load_random_entry(8'(slot), code);
    end
  endtask

  task automatic run_phase(input int sender_idle, input int sink_stall, input int items);
    idle_pct = sender_idle;
    stall_pct = sink_stall;
    repeat (items) random_item();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty table: nothing drawn, column still moves
    set_entries(9'd0);
    draw(8'h00);
    draw(8'hFF);
    start_text(4'd15, 8'd255);
    draw(8'h01);

    // Glyph pool at the bottom of the store and the last bytes before its end
    load_glyph(12'd0, 8'h00);
    load_glyph(12'd1, 8'hFF);
    for (int a = 2; a < GLYPH_POOL; a++)
      load_glyph(12'(a), 8'($urandom_range(0, 255)));
    for (int a = TAIL_BASE; a < GLYPH_BYTES_DEF; a++)
      load_glyph(12'(a), 8'($urandom_range(0, 255)));

    // Fill every table slot; first slots cover widest, empty, flat and overrun glyphs
    load_entry(8'd0, sorted_code(0), 6'd63, 2'd3, 12'd0);
    load_entry(8'd1, sorted_code(1), 6'd0, 2'd2, 12'd5);
    load_entry(8'd2, sorted_code(2), 6'd7, 2'd0, 12'd0);
    load_entry(8'd3, sorted_code(3), 6'd18, 2'd3, 12'(TAIL_BASE));
    load_entry(8'd4, sorted_code(4), 6'd1, 2'd1, 12'd63);
    for (int s = 5; s < TABLE_DEPTH_DEF; s++)
      load_random_entry(8'(s), sorted_code(s));

    // Full table: page and column wrap, each glyph shape, misses below the table and inside
    set_entries(9'd256);
    start_text(4'd15, 8'd250);
    draw(8'd1);
    draw(8'd3);
    draw(8'd5);
    draw(8'd7);
    draw(8'd0);
    draw(8'd2);
    draw(8'd255);
    draw(8'd9);
    start_text(4'd0, 8'd0);
    draw(8'd9);

    // Count beyond the table size
    set_entries(9'd511);
    draw(8'd255);
    draw(8'd201);

    // Partial table: codes past the last valid entry miss
    set_entries(9'd100);
    draw(8'd201);
    draw(8'd199);

    set_entries(9'd1);
    draw(8'd1);
    draw(8'd3);

    // Random traffic under several flow-control mixes
    set_entries(9'd256);
    run_phase(0, 0, PHASE_ITEMS);

    set_entries(9'($urandom_range(64, 256)));
    run_phase(54, 0, PHASE_ITEMS);

    // Long sink hold-off while the source keeps offering
    set_entries(9'd256);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    run_phase(0, 54, PHASE_ITEMS);

    set_entries(9'($urandom_range(64, 256)));
    run_phase(8, 8, PHASE_ITEMS);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
